/* hw/rtl/ptmap_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the page table mapper.
package ptmap_pkg;

  localparam int TABLE_PAGES = 16;
  localparam int IDX_W       = 9;
  localparam int ENTRIES     = 1 << IDX_W;
  localparam int PAGE_W      = $clog2(TABLE_PAGES);
  localparam int ADDR_W      = PAGE_W + IDX_W;
  localparam int DEPTH       = TABLE_PAGES * ENTRIES;
  localparam int NFP_W       = $clog2(TABLE_PAGES + 1);
  localparam int FRAME_W     = 40;
  localparam int VPN_W       = 36;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 52;

  localparam logic [1:0] STATUS_DONE       = 2'd0;
  localparam logic [1:0] STATUS_NOT_MAPPED = 2'd1;
  localparam logic [1:0] STATUS_NO_TABLES  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_ACTIVE = 1'd1;

  typedef struct packed {
    logic       load;
    logic       clear_all;
    logic       clear_page;
    logic       read;
    logic       wr_link;
    logic       wr_user;
    logic       wr_leaf;
    logic       advance;
    logic       set_status;
    logic [1:0] status_code;
    logic       load_out;
  } ptmap_cmd_t;

  typedef struct packed {
    logic clear_all_last;
    logic clear_page_last;
    logic entry_ok;
    logic user;
    logic unmap;
    logic no_pages;
    logic level_last;
    logic out_free;
  } ptmap_sts_t;

endpackage

/* hw/rtl/ptmap_ctrl.sv */
// Controller state machine sequencing the table clear, walk, allocation and response.
module ptmap_ctrl import ptmap_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ptmap_sts_t sts,
  output ptmap_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_READ  = 8'b0000_0100,
    ST_EVAL  = 8'b0000_1000,
    ST_ALLOC = 8'b0001_0000,
    ST_LINK  = 8'b0010_0000,
    ST_LEAF  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_INIT: begin
        cmd.clear_all = 1'b1;
        if (sts.clear_all_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.unmap) begin
          if (!sts.entry_ok) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = STATUS_NOT_MAPPED;
            state_next      = ST_DONE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = sts.level_last ? ST_LEAF : ST_READ;
          end
        end else if (!sts.entry_ok) begin
          if (sts.no_pages) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = STATUS_NO_TABLES;
            state_next      = ST_DONE;
          end else begin
            state_next = ST_ALLOC;
          end
        end else begin
          cmd.advance = 1'b1;
          cmd.wr_user = sts.user;
          state_next  = sts.level_last ? ST_LEAF : ST_READ;
        end
      end
      ST_ALLOC: begin
        cmd.clear_page = 1'b1;
        if (sts.clear_page_last) begin
          state_next = ST_LINK;
        end
      end
      ST_LINK: begin
        cmd.wr_link = 1'b1;
        state_next  = sts.level_last ? ST_LEAF : ST_READ;
      end
      ST_LEAF: begin
        cmd.wr_leaf = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

/* hw/rtl/ptmap_dp.sv */
// Datapath: table memory, request and walk registers, allocator, config and response registers.
module ptmap_dp import ptmap_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 command,
  input  logic [47:0]          virt_addr,
  input  logic [51:0]          phys_addr,
  input  logic [11:0]          low_flags,
  input  logic [11:0]          high_flags,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic                 invalidate,
  output logic [47:0]          invalidate_page,
  input  ptmap_cmd_t           cmd,
  output ptmap_sts_t           sts
);

  logic [63:0]        mem [DEPTH];
  logic [63:0]        entry;

  logic [FRAME_W-1:0] table_base;
  logic               root_active;

  logic               req_unmap;
  logic [VPN_W-1:0]   req_vpn;
  logic [FRAME_W-1:0] req_frame;
  logic [11:0]        req_low;
  logic [11:0]        req_high;
  logic [1:0]         req_status;

  logic [1:0]         level;
  logic [PAGE_W-1:0]  page;
  logic [NFP_W-1:0]   next_free;
  logic [ADDR_W-1:0]  clr_cnt;

  logic [IDX_W-1:0]   idx;
  logic [ADDR_W-1:0]  walk_addr;
  logic [FRAME_W-1:0] entry_off;
  logic [FRAME_W-1:0] new_frame;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [63:0]        mem_wdata;
  logic               done_ok;

  always_comb begin
    case (level)
      2'd3:    idx = req_vpn[35:27];
      2'd2:    idx = req_vpn[26:18];
      2'd1:    idx = req_vpn[17:9];
      default: idx = req_vpn[8:0];
    endcase
  end

  assign walk_addr = {page, idx};
  assign entry_off = entry[51:12] - table_base;
  assign new_frame = table_base + FRAME_W'(next_free);

  always_comb begin
    mem_we    = 1'b1;
    mem_waddr = walk_addr;
    mem_wdata = '0;
    if (cmd.clear_all) begin
      mem_waddr = clr_cnt;
    end else if (cmd.clear_page) begin
      mem_waddr = {next_free[PAGE_W-1:0], clr_cnt[IDX_W-1:0]};
    end else if (cmd.wr_link) begin
      mem_wdata = {12'h000, new_frame, 9'h000, req_low[2], 2'b11};
    end else if (cmd.wr_user) begin
      mem_wdata = {entry[63:3], 1'b1, entry[1:0]};
    end else if (cmd.wr_leaf) begin
      mem_wdata = req_unmap ? 64'h0 : {req_high, req_frame, req_low};
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      entry <= mem[walk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base  <= '0;
      root_active <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TABLE_BASE:  table_base  <= cfg_data[51:12];
        REG_ROOT_ACTIVE: root_active <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_unmap <= command;
      req_vpn   <= virt_addr[47:12];
      req_frame <= phys_addr[51:12];
      req_low   <= low_flags;
      req_high  <= high_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      next_free  <= NFP_W'(1);
      level      <= 2'd3;
      page       <= '0;
      req_status <= STATUS_DONE;
    end else begin
      if (cmd.clear_all) begin
        clr_cnt <= sts.clear_all_last ? '0 : clr_cnt + ADDR_W'(1);
      end else if (cmd.clear_page) begin
        clr_cnt <= sts.clear_page_last ? '0 : clr_cnt + ADDR_W'(1);
      end
      if (cmd.load) begin
        level      <= 2'd3;
        page       <= '0;
        req_status <= STATUS_DONE;
      end else if (cmd.wr_link) begin
        level     <= level - 2'd1;
        page      <= next_free[PAGE_W-1:0];
        next_free <= next_free + NFP_W'(1);
      end else if (cmd.advance) begin
        level <= level - 2'd1;
        page  <= entry_off[PAGE_W-1:0];
      end
      if (cmd.set_status) begin
        req_status <= cmd.status_code;
      end
    end
  end

  assign done_ok = (req_status == STATUS_DONE) && root_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status          <= req_status;
      invalidate      <= done_ok;
      invalidate_page <= done_ok ? {req_vpn, 12'h000} : 48'h0;
    end
  end

  assign sts.clear_all_last  = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign sts.clear_page_last = (clr_cnt[IDX_W-1:0] == {IDX_W{1'b1}});
  assign sts.entry_ok        = entry[0] && (entry_off < FRAME_W'(TABLE_PAGES));
  assign sts.user            = req_low[2];
  assign sts.unmap           = req_unmap;
  assign sts.no_pages        = (next_free >= NFP_W'(TABLE_PAGES));
  assign sts.level_last      = (level == 2'd1);
  assign sts.out_free        = !out_valid || out_ready;

endmodule

/* hw/rtl/four_level_page_table_mapper_core.sv */
// Top level of the four-level page table mapper: controller, datapath and checks.
//
// Maintains a four-level x86-64 page table in an internal memory of 16 table pages
// (8192 entries of 64 bits); page 0 is the root. After reset the memory is cleared
// one entry per cycle, so in_ready stays low until every entry is clear; configuration
// writes are taken throughout. A request takes a read and an evaluate state per upper
// level on the single table memory, then the leaf write and the response load; a walk
// that fails stops early and skips the leaf write. The next request is accepted only
// after the response is loaded into the output register. Each table page the walk
// allocates adds a clear of its 512 entries, one entry per cycle, and a link write.
// A finished result waits in the output register while the next request is accepted.
module four_level_page_table_mapper_core import ptmap_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [47:0]          virt_addr,
  input  logic [51:0]          phys_addr,
  input  logic [11:0]          low_flags,
  input  logic [11:0]          high_flags,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic                 invalidate,
  output logic [47:0]          invalidate_page
);

  ptmap_cmd_t cmd;
  ptmap_sts_t sts;

  ptmap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptmap_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .command         (command),
    .virt_addr       (virt_addr),
    .phys_addr       (phys_addr),
    .low_flags       (low_flags),
    .high_flags      (high_flags),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .invalidate      (invalidate),
    .invalidate_page (invalidate_page),
    .cmd             (cmd),
    .sts             (sts)
  );

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a walk is in progress");

  a_invalidate_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalidate |-> status == STATUS_DONE)
    else $error("invalidation requested on a failed request");

  a_invalidate_page_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> invalidate_page[11:0] == 12'h000)
    else $error("invalidation address not page aligned");

  a_no_invalidate_page_without_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && !invalidate |-> invalidate_page == 48'h0)
    else $error("invalidation address without invalidation request");

endmodule

/* test/tb_top.sv */
// Testbench for the page table mapper: directed and random map/unmap requests, predicted.
module tb_top;
  import ptmap_pkg::*;

  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_UNMAP = 1'b1;
  localparam logic [63:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
  localparam int QUIET_LIMIT = 40000;
  localparam int RAND_BLOCK  = 200;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        inv;
    logic [47:0] page;
  } walk_result_t;

  typedef struct packed {
    row_kind_t    kind;
    logic         cmd;
    logic [47:0]  va;
    logic [51:0]  pa;
    logic [11:0]  lf;
    logic [11:0]  hf;
    logic         typed;
    walk_result_t res;
    logic [51:0]  base;
    logic         active;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 command = CMD_MAP;
  logic [47:0]          virt_addr = '0;
  logic [51:0]          phys_addr = '0;
  logic [11:0]          low_flags = '0;
  logic [11:0]          high_flags = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic                 invalidate;
  logic [47:0]          invalidate_page;

  logic [63:0]  tbl_mem [DEPTH];
  int           alloc_next;
  logic [51:0]  base_reg;
  logic         active_reg;

  walk_result_t pending_walks [$];
  plan_row_t    plan_rows [$];
  int           errors = 0;
  int           quiet = 0;
  int           send_idle = 0;
  int           recv_idle = 0;

  four_level_page_table_mapper_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .virt_addr(virt_addr), .phys_addr(phys_addr),
    .low_flags(low_flags), .high_flags(high_flags),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .invalidate(invalidate), .invalidate_page(invalidate_page)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic walk_result_t map_walk(input logic cmd, input logic [47:0] va_in,
                                            input logic [51:0] pa_in, input logic [11:0] lf,
                                            input logic [11:0] hf);
    logic [47:0]  va;
    logic [47:0]  sh;
    logic [63:0]  e;
    logic [63:0]  off;
    logic [63:0]  base64;
    logic [63:0]  link;
    logic [63:0]  upper;
    logic         ok;
    logic [1:0]   st;
    int           page;
    int           nxt;
    int           lvl;
    int           slot;
    int           i;
    walk_result_t r;
    va = {va_in[47:12], 12'h000};
    base64 = {12'h000, base_reg} & FRAME_MASK;
    upper = lf[2] ? 64'h7 : 64'h3;
    page = 0;
    st = STATUS_DONE;
    for (lvl = 3; lvl >= 1 && st == STATUS_DONE; lvl--) begin
      sh = va >> (12 + 9 * lvl);
      slot = page * ENTRIES + int'(sh[8:0]);
      e = tbl_mem[slot];
      off = ((e & FRAME_MASK) - base64) & FRAME_MASK;
      ok = e[0] && ((off >> 12) < TABLE_PAGES);
      nxt = ok ? int'(off >> 12) : 0;
      if (cmd == CMD_MAP) begin
        if (!ok) begin
          if (alloc_next >= TABLE_PAGES) begin
            st = STATUS_NO_TABLES;
          end else begin
            nxt = alloc_next;
            for (i = 0; i < ENTRIES; i++) tbl_mem[nxt * ENTRIES + i] = '0;
            alloc_next++;
            link = 64'(nxt);
            link = (base64 + (link << 12)) & FRAME_MASK;
            tbl_mem[slot] = link | upper;
          end
        end else if (lf[2]) begin
          tbl_mem[slot] = e | 64'h4;
        end
      end else if (!ok) begin
        st = STATUS_NOT_MAPPED;
      end
      page = nxt;
    end
    if (st == STATUS_DONE) begin
      slot = page * ENTRIES + int'(va[20:12]);
      tbl_mem[slot] = (cmd == CMD_MAP) ? {hf, pa_in[51:12], lf} : 64'h0;
    end
    r.status = st;
    r.inv = (st == STATUS_DONE) && active_reg;
    r.page = r.inv ? va : 48'h0;
    return r;
  endfunction

  function automatic plan_row_t req_row(input logic cmd, input logic [47:0] va,
                                        input logic [51:0] pa, input logic [11:0] lf,
                                        input logic [11:0] hf);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.cmd = cmd;
    r.va = va;
    r.pa = pa;
    r.lf = lf;
    r.hf = hf;
    return r;
  endfunction

  function automatic plan_row_t with_result(input plan_row_t row, input logic [1:0] st,
                                            input logic inv, input logic [47:0] pg);
    plan_row_t r;
    r = row;
    r.typed = 1'b1;
    r.res.status = st;
    r.res.inv = inv;
    r.res.page = pg;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [51:0] base, input logic active);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.base = base;
    r.active = active;
    return r;
  endfunction

  function automatic logic [47:0] route_prefix(input int k);
    case (k)
      0: return 48'h0000_0000_0000;
      1: return 48'h0000_0020_0000;
      2: return 48'h0000_4000_0000;
      3: return 48'h0080_0000_0000;
      4: return 48'hFFFF_FFFF_F000;
      default: return 48'h5555_5555_5000;
    endcase
  endfunction

  task automatic post_request(input plan_row_t row);
    walk_result_t got;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= row.cmd;
    virt_addr <= row.va;
    phys_addr <= row.pa;
    low_flags <= row.lf;
    high_flags <= row.hf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = map_walk(row.cmd, row.va, row.pa, row.lf, row.hf);
    if (row.typed) begin
      pending_walks.push_back(row.res);
    end else begin
      pending_walks.push_back(got);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_walks.size() != 0) @(posedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [51:0] base, input logic active);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_TABLE_BASE;
    cfg_data <= base | 52'($urandom_range(4095));
    base_reg = base;
    @(negedge clk);
    cfg_index <= REG_ROOT_ACTIVE;
    cfg_data <= {51'({$urandom, $urandom}), active};
    active_reg = active;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin : check_results
    walk_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_walks.size() == 0) begin
        $display("%0t: unexpected result, status %0d page %h", $time, status,
                 invalidate_page);
        errors = errors + 1;
      end else begin
        want = pending_walks.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors = errors + 1;
        end
        if (invalidate !== want.inv) begin
          $display("%0t: invalidate expected %0d actual %0d", $time, want.inv, invalidate);
          errors = errors + 1;
        end
        if (invalidate_page !== want.page) begin
          $display("%0t: invalidate_page expected %h actual %h", $time, want.page,
                   invalidate_page);
          errors = errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    plan_row_t   row;
    logic [47:0] prefix;
    logic [51:0] nb;
    logic        na;
    int          i;
    int          ph;
    int          blk;
    int          k;
    int          roll;
    for (i = 0; i < DEPTH; i++) tbl_mem[i] = '0;
    alloc_next = 1;
    base_reg = '0;
    active_reg = 1'b1;

    plan_rows.push_back(with_result(req_row(CMD_UNMAP, 48'h0, 52'h0, 12'h000, 12'h000),
                                    STATUS_NOT_MAPPED, 1'b0, 48'h0));
    plan_rows.push_back(with_result(req_row(CMD_MAP, 48'h0, 52'h0, 12'h000, 12'h000),
                                    STATUS_DONE, 1'b1, 48'h0));
    plan_rows.push_back(with_result(req_row(CMD_MAP, 48'hFFFF_FFFF_FFFF,
                                            52'hF_FFFF_FFFF_FFFF, 12'hFFF, 12'hFFF),
                                    STATUS_DONE, 1'b1, 48'hFFFF_FFFF_F000));
    plan_rows.push_back(with_result(req_row(CMD_UNMAP, 48'hFFFF_FFFF_FFFF, 52'h0,
                                            12'h000, 12'h000),
                                    STATUS_DONE, 1'b1, 48'hFFFF_FFFF_F000));
    plan_rows.push_back(with_result(req_row(CMD_UNMAP, 48'hFFFF_FFFF_F000, 52'h0,
                                            12'h000, 12'h000),
                                    STATUS_DONE, 1'b1, 48'hFFFF_FFFF_F000));
    plan_rows.push_back(with_result(req_row(CMD_MAP, 48'h0000_0000_1FFF,
                                            52'h0_0000_1234_5000, 12'h007, 12'h800),
                                    STATUS_DONE, 1'b1, 48'h0000_0000_1000));
    plan_rows.push_back(with_result(req_row(CMD_UNMAP, 48'h0080_0000_0000, 52'h0,
                                            12'h000, 12'h000),
                                    STATUS_NOT_MAPPED, 1'b0, 48'h0));
    plan_rows.push_back(req_row(CMD_MAP, 48'h0080_0000_0000, 52'h8_0000_0000_0000,
                                12'h003, 12'h000));
    plan_rows.push_back(req_row(CMD_MAP, 48'h0000_4000_0000, 52'h0_0000_0000_0FFF,
                                12'h005, 12'h001));
    plan_rows.push_back(req_row(CMD_MAP, 48'h0000_0020_0000, 52'h1_0000_0000_1000,
                                12'h0F3, 12'h7FF));
    plan_rows.push_back(req_row(CMD_MAP, 48'h5555_5555_5555, 52'hA_AAAA_AAAA_AAAA,
                                12'hAAA, 12'h555));
    plan_rows.push_back(with_result(req_row(CMD_MAP, 48'hAAAA_AAAA_AAAA,
                                            52'h5_5555_5555_5555, 12'h555, 12'hAAA),
                                    STATUS_NO_TABLES, 1'b0, 48'h0));
    plan_rows.push_back(with_result(req_row(CMD_MAP, 48'h0000_8000_0000,
                                            52'h0_0000_0000_0000, 12'h004, 12'h000),
                                    STATUS_NO_TABLES, 1'b0, 48'h0));
    plan_rows.push_back(with_result(req_row(CMD_UNMAP, 48'h0000_8000_0000, 52'h0,
                                            12'h000, 12'h000),
                                    STATUS_NOT_MAPPED, 1'b0, 48'h0));
    plan_rows.push_back(cfg_row(52'h0, 1'b0));
    plan_rows.push_back(with_result(req_row(CMD_MAP, 48'h0000_0000_3000,
                                            52'h0_0000_0000_7000, 12'h007, 12'h000),
                                    STATUS_DONE, 1'b0, 48'h0));
    plan_rows.push_back(with_result(req_row(CMD_UNMAP, 48'h0000_0000_1000, 52'h0,
                                            12'h000, 12'h000),
                                    STATUS_DONE, 1'b0, 48'h0));
    plan_rows.push_back(cfg_row(52'hF_FFFF_FFFF_F000, 1'b1));
    plan_rows.push_back(req_row(CMD_MAP, 48'h0, 52'h0_0000_0000_9000, 12'h001, 12'h000));
    plan_rows.push_back(req_row(CMD_UNMAP, 48'hFFFF_FFFF_F000, 52'h0, 12'h000, 12'h000));
    plan_rows.push_back(req_row(CMD_MAP, 48'h0080_0000_0000, 52'h0_0000_0000_A000,
                                12'h004, 12'h800));
    plan_rows.push_back(cfg_row(52'h0, 1'b1));
    plan_rows.push_back(req_row(CMD_MAP, 48'h0000_0000_2000, 52'h0_0000_0000_B000,
                                12'h003, 12'h000));
    plan_rows.push_back(req_row(CMD_UNMAP, 48'h5555_5555_5000, 52'h0, 12'h000, 12'h000));

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    apply_setting(52'h0, 1'b1);

    foreach (plan_rows[i]) begin
      if (plan_rows[i].kind == ROW_CFG) begin
        settle();
        apply_setting(plan_rows[i].base, plan_rows[i].active);
      end else begin
        post_request(plan_rows[i]);
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 13;
          recv_idle = 82;
        end
        1: begin
          send_idle = 82;
          recv_idle = 13;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (blk = 0; blk < 3; blk++) begin
        k = ph * 3 + blk;
        case (k)
          1: begin
            nb = 52'h0;
            na = 1'b0;
          end
          2: begin
            nb = 52'({$urandom, $urandom});
            na = 1'b1;
          end
          4: begin
            nb = 52'h0_0000_0000_1000;
            na = 1'b1;
          end
          6: begin
            nb = 52'hF_FFFF_FFFF_F000;
            na = 1'b0;
          end
          8: begin
            nb = 52'({$urandom, $urandom});
            na = 1'b0;
          end
          default: begin
            nb = 52'h0;
            na = 1'b1;
          end
        endcase
        settle();
        apply_setting(nb, na);
        for (i = 0; i < RAND_BLOCK; i++) begin
          roll = $urandom_range(99);
          if (roll < 70) begin
            prefix = route_prefix($urandom_range(5));
          end else if (roll < 85) begin
            prefix = {9'(route_prefix($urandom_range(5)) >> 39),
                      9'(route_prefix($urandom_range(5)) >> 30),
                      9'(route_prefix($urandom_range(5)) >> 21), 21'h0};
          end else begin
            prefix = 48'({$urandom, $urandom});
          end
          row = req_row(($urandom_range(99) < 65) ? CMD_MAP : CMD_UNMAP,
                        {prefix[47:21], 21'($urandom)}, 52'({$urandom, $urandom}),
                        12'($urandom), 12'($urandom));
          post_request(row);
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ptmap_pkg.sv
hw/rtl/ptmap_ctrl.sv
hw/rtl/ptmap_dp.sv
hw/rtl/four_level_page_table_mapper_core.sv
test/tb_top.sv
